@@ hdl/trap_pkg.sv @@
// trap_pkg: shared codes, constants and helpers for the trapezoidal motion profile
// depends on nothing; used by trapezoidal_motion_profile
package trap_pkg;

  // input action codes
  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_START  = 3'd1;
  localparam logic [2:0] ACT_STOP   = 3'd2;
  localparam logic [2:0] ACT_IDLE   = 3'd3;
  localparam logic [2:0] ACT_ADJUST = 3'd4;
  localparam logic [2:0] ACT_SET    = 3'd5;

  // profile phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_ACCEL = 2'd1;
  localparam logic [1:0] PH_BRAKE = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_DIST  = 3'd0;
  localparam logic [2:0] CFG_TOP   = 3'd1;
  localparam logic [2:0] CFG_END   = 3'd2;
  localparam logic [2:0] CFG_ACCEL = 3'd3;
  localparam logic [2:0] CFG_TICK  = 3'd4;

  // q16.16 constants, and the default tick interval TICK_RST in q0.24
  localparam logic [31:0] ONE_Q16   = 32'h0001_0000;
  localparam logic [31:0] CREEP_Q16 = 32'h0005_0000;
  localparam logic [32:0] CLOSE_Q16 = 33'h0_0000_2000;
  localparam logic [31:0] MAX_Q16   = 32'h7FFF_FFFF;
  localparam logic [31:0] MIN_Q16   = 32'h8000_0000;
  localparam logic [23:0] TICK_RST  = 24'd33554;

  // sequencer states
  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_DV   = 10'b00_0000_0010,
    ST_VV   = 10'b00_0000_0100,
    ST_FF   = 10'b00_0000_1000,
    ST_AR   = 10'b00_0001_0000,
    ST_BRK  = 10'b00_0010_0000,
    ST_VEL  = 10'b00_0100_0000,
    ST_SGO  = 10'b00_1000_0000,
    ST_STEP = 10'b01_0000_0000,
    ST_OUT  = 10'b10_0000_0000
  } trap_state_t;

  // magnitude of a signed word, saturated to the positive range
  function automatic logic [31:0] mag_sat(input logic [31:0] x);
    logic [31:0] m;
    m = x[31] ? (x == MIN_Q16 ? MAX_Q16 : (~x + 32'd1)) : x;
    return m;
  endfunction

endpackage

@@ hdl/trapezoidal_motion_profile.sv @@
// trapezoidal_motion_profile: one-axis trapezoidal speed profile, q16.16 fixed point
// depends on trap_pkg and trap_mul
//
// Usage: each transfer on the in_ channel carries an action (in_tuser) and a value
// (in_tdata); each one produces exactly one transfer on the out_ channel with the
// position, speed and phase after the action. Move registers are loaded through the
// cfg_ write port; the user must write them only while the block is idle, which the
// block does not enforce. A start action latches them. Actions other than a tick, and
// a tick in the idle phase, pass straight to the output step. A tick with a profile
// running goes through four products on the shared bit-serial multiplier, the brake,
// speed and step-start steps, a fifth product and the output step, in that order.
// Throughput: one item at a time; in_tready rises again once the result has moved
// into the output register, so the next item is taken while that result waits.
// Reset (rst_n low, synchronous) clears the profile state, sets the registers to
// their defaults and empties the output register.
// A stalled receiver holds the result in out_tdata; a finished item whose result
// cannot enter the full output register waits, and no new item is taken.
module trapezoidal_motion_profile (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [2:0]  in_tuser,   // [2:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [31:0] position_out, [63:32] speed_out, [65:64] phase
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  trap_pkg::trap_state_t state_r, state_nxt;

  // configuration registers
  logic [31:0] md_r, ts_r, es_r, ar_r;
  logic [23:0] ti_r;

  // profile state
  logic [31:0] pos_r, pos_nxt, spd_r, spd_nxt, tgt_r, tgt_nxt;
  logic [31:0] goal_r, goal_nxt, gspd_r, gspd_nxt, acc_r, acc_nxt;
  logic        dir_r, dir_nxt;
  logic [1:0]  mode_r, mode_nxt;

  // per-tick working registers
  logic [31:0] dv_r, dv_nxt;
  logic [63:0] vv_r, vv_nxt, d_r, d_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic        brk_r, brk_nxt;

  // output register
  logic        ov_r, ov_nxt;
  logic [31:0] opos_r, ospd_r;
  logic [1:0]  oph_r;
  logic        oload;

  // multiplier hookup
  logic        mul_start, mul_done;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_prod;

  // helpers
  logic               in_xfer;
  logic [31:0]        spd_mag, gspd_mag, acc_floor, dist_mag, fin, top_mag, fin_mag, step_mag;
  logic [32:0]        pos_abs, rem_calc;
  logic signed [32:0] s33, t33, inc33, dec33, step33, adj33;
  logic signed [33:0] psum34;
  logic [63:0]        ar2;

  trap_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign in_tready  = (state_r == trap_pkg::ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = ov_r;
  assign out_tdata  = {6'd0, oph_r, ospd_r, opos_r};

  // shared operand helpers
  always_comb begin
    spd_mag   = spd_r[31] ? (~spd_r + 32'd1) : spd_r;
    gspd_mag  = gspd_r[31] ? (~gspd_r + 32'd1) : gspd_r;
    acc_floor = (acc_r >= trap_pkg::ONE_Q16) ? acc_r : trap_pkg::ONE_Q16;
    pos_abs   = pos_r[31] ? ({1'b0, ~pos_r} + 33'd1) : {1'b0, pos_r};
    rem_calc  = {1'b0, goal_r} - pos_abs;
    dist_mag  = trap_pkg::mag_sat(md_r);
    fin       = ($signed(es_r) > $signed(ts_r)) ? ts_r : es_r;
    top_mag   = trap_pkg::mag_sat(ts_r);
    fin_mag   = trap_pkg::mag_sat(fin);
    s33       = $signed({spd_r[31], spd_r});
    t33       = $signed({tgt_r[31], tgt_r});
    inc33     = s33 + $signed({1'b0, dv_r});
    dec33     = s33 - $signed({1'b0, dv_r});
    step_mag  = mul_prod[55:24];
    step33    = spd_r[31] ? -$signed({1'b0, step_mag}) : $signed({1'b0, step_mag});
    psum34    = $signed({pos_r[31], pos_r[31], pos_r}) + $signed({step33[32], step33});
    adj33     = $signed({pos_r[31], pos_r}) + $signed({in_tdata[31], in_tdata});
    ar2       = {mul_prod[62:0], 1'b0};
  end

  // sequencer and profile update
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    spd_nxt   = spd_r;
    tgt_nxt   = tgt_r;
    goal_nxt  = goal_r;
    gspd_nxt  = gspd_r;
    acc_nxt   = acc_r;
    dir_nxt   = dir_r;
    mode_nxt  = mode_r;
    dv_nxt    = dv_r;
    vv_nxt    = vv_r;
    d_nxt     = d_r;
    rem_nxt   = rem_r;
    brk_nxt   = brk_r;
    mul_start = 1'b0;
    mul_a     = 32'd0;
    mul_b     = 32'd0;
    oload     = 1'b0;
    ov_nxt    = ov_r && !out_tready;

    unique case (state_r)
      trap_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = trap_pkg::ST_OUT;
          unique case (in_tuser)
            trap_pkg::ACT_TICK: begin
              if (mode_r != trap_pkg::PH_IDLE) begin
                rem_nxt   = rem_calc;
                mul_start = 1'b1;
                mul_a     = acc_r;
                mul_b     = {8'd0, ti_r};
                state_nxt = trap_pkg::ST_DV;
              end
            end
            trap_pkg::ACT_START: begin
              dir_nxt = md_r[31];
              if (dist_mag < trap_pkg::ONE_Q16) begin
                mode_nxt = trap_pkg::PH_DONE;
              end else begin
                pos_nxt  = 32'd0;
                goal_nxt = dist_mag;
                tgt_nxt  = md_r[31] ? (~top_mag + 32'd1) : top_mag;
                gspd_nxt = md_r[31] ? (~fin_mag + 32'd1) : fin_mag;
                acc_nxt  = trap_pkg::mag_sat(ar_r);
                mode_nxt = trap_pkg::PH_ACCEL;
              end
            end
            trap_pkg::ACT_STOP: begin
              tgt_nxt  = 32'd0;
              spd_nxt  = 32'd0;
              mode_nxt = trap_pkg::PH_DONE;
            end
            trap_pkg::ACT_IDLE: begin
              pos_nxt  = 32'd0;
              spd_nxt  = 32'd0;
              tgt_nxt  = 32'd0;
              mode_nxt = trap_pkg::PH_IDLE;
            end
            trap_pkg::ACT_ADJUST: begin
              if (adj33[32] != adj33[31]) begin
                pos_nxt = adj33[32] ? trap_pkg::MIN_Q16 : trap_pkg::MAX_Q16;
              end else begin
                pos_nxt = adj33[31:0];
              end
            end
            trap_pkg::ACT_SET: begin
              pos_nxt = in_tdata;
            end
            default: begin
            end
          endcase
        end
      end
      trap_pkg::ST_DV: begin
        if (mul_done) begin
          dv_nxt    = mul_prod[55:24];
          mul_start = 1'b1;
          mul_a     = spd_mag;
          mul_b     = spd_mag;
          state_nxt = trap_pkg::ST_VV;
        end
      end
      trap_pkg::ST_VV: begin
        if (mul_done) begin
          vv_nxt    = mul_prod;
          mul_start = 1'b1;
          mul_a     = gspd_mag;
          mul_b     = gspd_mag;
          state_nxt = trap_pkg::ST_FF;
        end
      end
      trap_pkg::ST_FF: begin
        if (mul_done) begin
          d_nxt     = (vv_r >= mul_prod) ? (vv_r - mul_prod) : (mul_prod - vv_r);
          mul_start = 1'b1;
          mul_a     = acc_floor;
          mul_b     = rem_r[31:0];
          state_nxt = trap_pkg::ST_AR;
        end
      end
      trap_pkg::ST_AR: begin
        if (mul_done) begin
          brk_nxt   = rem_r[32] || (ar2 < d_r);
          state_nxt = trap_pkg::ST_BRK;
        end
      end
      // switch to braking once the remaining distance is short
      trap_pkg::ST_BRK: begin
        if (mode_r == trap_pkg::PH_ACCEL && brk_r) begin
          mode_nxt = trap_pkg::PH_BRAKE;
          if (gspd_r == 32'd0) begin
            tgt_nxt = dir_r ? (~trap_pkg::CREEP_Q16 + 32'd1) : trap_pkg::CREEP_Q16;
          end else begin
            tgt_nxt = gspd_r;
          end
        end
        state_nxt = trap_pkg::ST_VEL;
      end
      // ramp speed toward target without passing it
      trap_pkg::ST_VEL: begin
        if (s33 < t33) begin
          spd_nxt = (inc33 > t33) ? tgt_r : inc33[31:0];
        end else if (s33 > t33) begin
          spd_nxt = (dec33 < t33) ? tgt_r : dec33[31:0];
        end
        state_nxt = trap_pkg::ST_SGO;
      end
      trap_pkg::ST_SGO: begin
        mul_start = 1'b1;
        mul_a     = spd_mag;
        mul_b     = {8'd0, ti_r};
        state_nxt = trap_pkg::ST_STEP;
      end
      // integrate position and check for arrival
      trap_pkg::ST_STEP: begin
        if (mul_done) begin
          if (psum34 > $signed({2'b00, trap_pkg::MAX_Q16})) begin
            pos_nxt = trap_pkg::MAX_Q16;
          end else if (psum34 < $signed({2'b11, trap_pkg::MIN_Q16})) begin
            pos_nxt = trap_pkg::MIN_Q16;
          end else begin
            pos_nxt = psum34[31:0];
          end
          if (mode_r != trap_pkg::PH_DONE && $signed(rem_r) < $signed(trap_pkg::CLOSE_Q16)) begin
            mode_nxt = trap_pkg::PH_DONE;
            tgt_nxt  = gspd_r;
          end
          state_nxt = trap_pkg::ST_OUT;
        end
      end
      // hand the result to the output register
      trap_pkg::ST_OUT: begin
        if (!ov_r || out_tready) begin
          oload     = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = trap_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = trap_pkg::ST_IDLE;
      end
    endcase
  end

  // control state, profile state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= trap_pkg::ST_IDLE;
      ov_r    <= 1'b0;
      md_r    <= 32'd0;
      ts_r    <= 32'd0;
      es_r    <= 32'd0;
      ar_r    <= 32'd0;
      ti_r    <= trap_pkg::TICK_RST;
      pos_r   <= 32'd0;
      spd_r   <= 32'd0;
      tgt_r   <= 32'd0;
      goal_r  <= 32'd0;
      gspd_r  <= 32'd0;
      acc_r   <= 32'd0;
      dir_r   <= 1'b0;
      mode_r  <= trap_pkg::PH_IDLE;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      pos_r   <= pos_nxt;
      spd_r   <= spd_nxt;
      tgt_r   <= tgt_nxt;
      goal_r  <= goal_nxt;
      gspd_r  <= gspd_nxt;
      acc_r   <= acc_nxt;
      dir_r   <= dir_nxt;
      mode_r  <= mode_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          trap_pkg::CFG_DIST:  md_r <= cfg_wdata;
          trap_pkg::CFG_TOP:   ts_r <= cfg_wdata;
          trap_pkg::CFG_END:   es_r <= cfg_wdata;
          trap_pkg::CFG_ACCEL: ar_r <= cfg_wdata;
          trap_pkg::CFG_TICK:  ti_r <= cfg_wdata[23:0];
          default: begin
          end
        endcase
      end
    end
  end

  // working and output payload registers
  always_ff @(posedge clk) begin
    dv_r  <= dv_nxt;
    vv_r  <= vv_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    brk_r <= brk_nxt;
    if (oload) begin
      opos_r <= pos_r;
      ospd_r <= spd_r;
      oph_r  <= mode_r;
    end
  end

endmodule

@@ hdl/trap_mul.sv @@
// trap_mul: bit-serial shift-add multiplier, 32 x 32 unsigned, one multiplier bit a cycle
// stand-alone; used by trapezoidal_motion_profile
module trap_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [63:0] prod
);

  logic [31:0] a_r;
  logic [63:0] prod_r, prod_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] sum;

  // one partial product per cycle, shifted in from the top
  always_comb begin
    sum      = {1'b0, prod_r[63:32]} + (prod_r[0] ? {1'b0, a_r} : 33'd0);
    prod_nxt = prod_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      prod_nxt = {32'd0, b};
      cnt_nxt  = 5'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      prod_nxt = {sum, prod_r[31:1]};
      cnt_nxt  = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    prod_r <= prod_nxt;
    if (start) begin
      a_r <= a;
    end
  end

  assign done = done_r;
  assign prod = prod_r;

endmodule
